>>> hw/rtl/vegm_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types of the voice envelope gain mixer.
// No dependencies; used by the interfaces, vegm_cfg, vegm_core and the top level.
package vegm_pkg;

  localparam int SAMPLE_BITS_DEF = 24;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_VOLUME = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME_UP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME_DOWN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_STEP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEREO_SOURCE = 3'd5;

  localparam logic [1:0] ACT_FRAME = 2'd0;
  localparam logic [1:0] ACT_ON    = 2'd1;
  localparam logic [1:0] ACT_OFF   = 2'd2;
  localparam logic [1:0] ACT_KILL  = 2'd3;

  localparam logic [16:0] ENV_ONE    = 17'd65536;
  localparam logic [15:0] VOL_UNITY  = 16'd4096;

  localparam logic [15:0] RST_TARGET_VOLUME = 16'd4096;
  localparam logic [16:0] RST_VOLUME_UP     = 17'd65908;
  localparam logic [16:0] RST_VOLUME_DOWN   = 17'd65164;
  localparam logic [16:0] RST_ATTACK_STEP   = 17'd64;
  localparam logic [16:0] RST_RELEASE_STEP  = 17'd64;
  localparam logic        RST_STEREO_SOURCE = 1'b1;

  typedef struct packed {
    logic [15:0] target_volume;
    logic [16:0] volume_up_factor;
    logic [16:0] volume_down_factor;
    logic [16:0] attack_step;
    logic [16:0] release_step;
    logic        stereo_source;
  } vegm_cfg_t;

endpackage

>>> hw/rtl/vegm_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the voice envelope gain mixer: input frames, results, register writes.
// Depends on vegm_pkg.
interface vegm_in_if #(parameter int SAMPLE_BITS = vegm_pkg::SAMPLE_BITS_DEF) ();
  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic signed [SAMPLE_BITS-1:0] source_left;
  logic signed [SAMPLE_BITS-1:0] source_right;
  logic                          source_present;
  logic signed [SAMPLE_BITS-1:0] mix_in_left;
  logic signed [SAMPLE_BITS-1:0] mix_in_right;
  logic [15:0]                   note_volume;
  logic [15:0]                   delay_frames;
  logic                          block_end;

  modport source (output valid, action, source_left, source_right, source_present,
                  mix_in_left, mix_in_right, note_volume, delay_frames, block_end,
                  input ready);
  modport sink (input valid, action, source_left, source_right, source_present,
                mix_in_left, mix_in_right, note_volume, delay_frames, block_end,
                output ready);
endinterface

interface vegm_out_if #(parameter int SAMPLE_BITS = vegm_pkg::SAMPLE_BITS_DEF) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_left;
  logic signed [SAMPLE_BITS-1:0] out_right;
  logic                          playing;
  logic [16:0]                   envelope_level;

  modport source (output valid, out_left, out_right, playing, envelope_level, input ready);
  modport sink (input valid, out_left, out_right, playing, envelope_level, output ready);
endinterface

interface vegm_cfg_if ();
  logic                             valid;
  logic                             ready;
  logic [vegm_pkg::CFG_IDX_W-1:0]   index;
  logic [vegm_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/vegm_mul.sv
`timescale 1ns / 1ps
// Shared signed-by-unsigned multiplier of the gain datapath.
// No dependencies; instantiated by vegm_core.
module vegm_mul #(
  parameter int A_W = 33,
  parameter int B_W = 17
) (
  input  logic signed [A_W-1:0]     a,
  input  logic        [B_W-1:0]     b,
  output logic signed [A_W+B_W:0]   p
);

  logic signed [B_W:0] b_s;

  assign b_s = $signed({1'b0, b});
  assign p   = a * b_s;

endmodule

>>> hw/rtl/vegm_cfg.sv
`timescale 1ns / 1ps
// Configuration register bank of the voice envelope gain mixer.
// Depends on vegm_pkg and vegm_cfg_if.
module vegm_cfg (
  input  logic                clk,
  input  logic                rst_n,
  vegm_cfg_if.sink            cfg_ch,
  output vegm_pkg::vegm_cfg_t cfg
);

  vegm_pkg::vegm_cfg_t cfg_r;
  vegm_pkg::vegm_cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        vegm_pkg::REG_TARGET_VOLUME: cfg_nxt.target_volume      = cfg_ch.data[15:0];
        vegm_pkg::REG_VOLUME_UP:     cfg_nxt.volume_up_factor   = cfg_ch.data;
        vegm_pkg::REG_VOLUME_DOWN:   cfg_nxt.volume_down_factor = cfg_ch.data;
        vegm_pkg::REG_ATTACK_STEP:   cfg_nxt.attack_step        = cfg_ch.data;
        vegm_pkg::REG_RELEASE_STEP:  cfg_nxt.release_step       = cfg_ch.data;
        vegm_pkg::REG_STEREO_SOURCE: cfg_nxt.stereo_source      = cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_volume      <= vegm_pkg::RST_TARGET_VOLUME;
      cfg_r.volume_up_factor   <= vegm_pkg::RST_VOLUME_UP;
      cfg_r.volume_down_factor <= vegm_pkg::RST_VOLUME_DOWN;
      cfg_r.attack_step        <= vegm_pkg::RST_ATTACK_STEP;
      cfg_r.release_step       <= vegm_pkg::RST_RELEASE_STEP;
      cfg_r.stereo_source      <= vegm_pkg::RST_STEREO_SOURCE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> hw/rtl/vegm_core.sv
`timescale 1ns / 1ps
// Voice state, sequencer and gain datapath around one shared multiplier.
// Depends on vegm_pkg, vegm_if and vegm_mul.
module vegm_core #(
  parameter int SAMPLE_BITS = vegm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  vegm_pkg::vegm_cfg_t cfg,
  vegm_in_if.sink             in_ch,
  vegm_out_if.source          out_ch
);

  localparam int SB = SAMPLE_BITS;
  localparam int MA = ((SB > 17) ? SB : 17) + 1;
  localparam int PW = MA + 18;
  localparam int AW = SB + 33;
  localparam int SW = SB + 10;

  localparam logic signed [AW-1:0] RND = {{(AW-24){1'b0}}, 1'b1, 23'b0};
  localparam logic signed [SW-1:0] SAT_HI = {{(SW-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {{(SW-SB+1){1'b1}}, {(SB-1){1'b0}}};

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DEC  = 4'd1;
  localparam logic [3:0] ST_G    = 4'd2;
  localparam logic [3:0] ST_G2   = 4'd3;
  localparam logic [3:0] ST_LL   = 4'd4;
  localparam logic [3:0] ST_LH   = 4'd5;
  localparam logic [3:0] ST_RL   = 4'd6;
  localparam logic [3:0] ST_RH   = 4'd7;
  localparam logic [3:0] ST_SL   = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;

  logic [3:0] st_r, st_nxt;

  // latched beat
  logic [1:0]           act_r, act_nxt;
  logic signed [SB-1:0] src_l_r, src_l_nxt;
  logic signed [SB-1:0] src_r_r, src_r_nxt;
  logic                 pres_r, pres_nxt;
  logic signed [SB-1:0] mix_l_r, mix_l_nxt;
  logic signed [SB-1:0] mix_r_r, mix_r_nxt;
  logic [15:0]          note_r, note_nxt;
  logic [15:0]          dly_r, dly_nxt;
  logic                 blk_r, blk_nxt;

  // datapath
  logic [15:0]          g_r, g_nxt;
  logic [31:0]          g2_r, g2_nxt;
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic signed [SB-1:0] res_l_r, res_l_nxt;
  logic signed [SB-1:0] res_r_r, res_r_nxt;

  // voice state
  logic [16:0] env_r, env_nxt;
  logic        att_r, att_nxt;
  logic        rel_r, rel_nxt;
  logic        play_r, play_nxt;
  logic        stop_r, stop_nxt;
  logic [15:0] vol_r, vol_nxt;
  logic [15:0] held_r, held_nxt;
  logic [15:0] sdl_r, sdl_nxt;
  logic [15:0] rdl_r, rdl_nxt;

  // result register
  logic                 ov_r, ov_nxt;
  logic signed [SB-1:0] o_l_r, o_l_nxt;
  logic signed [SB-1:0] o_r_r, o_r_nxt;
  logic                 o_play_r, o_play_nxt;
  logic [16:0]          o_env_r, o_env_nxt;

  logic signed [MA-1:0] mul_a;
  logic [16:0]          mul_b;
  logic signed [PW-1:0] mul_p;
  logic signed [AW-1:0] p_ext;
  logic signed [SB-1:0] src_sel;

  logic signed [SB+8:0] rnd_v;
  logic signed [SB-1:0] mix_sel;
  logic signed [SW-1:0] sum_v;
  logic signed [SB-1:0] sat_v;

  logic        vol_up;
  logic [33:0] up_sum;
  logic [17:0] up_v;
  logic [16:0] dn_v;
  logic [15:0] vol_st;

  logic [17:0] env_add;
  logic [16:0] env_st;
  logic        att_st;
  logic        rel_st;
  logic        stop_st;
  logic        stop_dec;

  vegm_mul #(.A_W(MA), .B_W(17)) u_mul (
    .a (mul_a),
    .b (mul_b),
    .p (mul_p)
  );

  assign in_ch.ready           = (st_r == ST_IDLE);
  assign out_ch.valid          = ov_r;
  assign out_ch.out_left       = o_l_r;
  assign out_ch.out_right      = o_r_r;
  assign out_ch.playing        = o_play_r;
  assign out_ch.envelope_level = o_env_r;

  assign src_sel = ((st_r == ST_RL) || (st_r == ST_RH))
                   ? (cfg.stereo_source ? src_r_r : src_l_r) : src_l_r;
  assign vol_up  = (vol_r < cfg.target_volume);

  always_comb begin
    mul_a = MA'(src_sel);
    mul_b = 17'(g2_r[15:0]);
    case (st_r) inside
      ST_G: begin
        mul_a = $signed(MA'(env_r));
        mul_b = 17'(vol_r);
      end
      ST_G2: begin
        mul_a = $signed(MA'(g_r));
        mul_b = 17'(held_r);
      end
      ST_LH, ST_RH: mul_b = 17'(g2_r[31:16]);
      ST_SL: begin
        mul_a = $signed(MA'(vol_r));
        mul_b = vol_up ? cfg.volume_up_factor : cfg.volume_down_factor;
      end
      default: ;
    endcase
  end

  assign p_ext = AW'(mul_p);

  // round to nearest, add into mix, saturate
  assign rnd_v   = acc_r[AW-1:24];
  assign mix_sel = (st_r == ST_RL) ? mix_l_r : mix_r_r;
  assign sum_v   = SW'(rnd_v) + SW'(mix_sel);

  always_comb begin
    if (sum_v > SAT_HI) begin
      sat_v = SAT_HI[SB-1:0];
    end else if (sum_v < SAT_LO) begin
      sat_v = SAT_LO[SB-1:0];
    end else begin
      sat_v = sum_v[SB-1:0];
    end
  end

  // volume slew
  assign up_sum = {1'b0, mul_p[32:0]} + 34'd65535;
  assign up_v   = up_sum[33:16];
  assign dn_v   = mul_p[32:16];

  always_comb begin
    vol_st = vol_r;
    if (vol_up) begin
      if (up_v > {2'b0, cfg.target_volume}) begin
        vol_st = cfg.target_volume;
      end else begin
        vol_st = up_v[15:0];
      end
    end else if (vol_r > cfg.target_volume) begin
      if (dn_v < {1'b0, cfg.target_volume}) begin
        vol_st = cfg.target_volume;
      end else begin
        vol_st = dn_v[15:0];
      end
    end
  end

  // envelope step, then release countdown
  assign env_add = {1'b0, env_r} + {1'b0, cfg.attack_step};

  always_comb begin
    env_st  = env_r;
    att_st  = att_r;
    rel_st  = rel_r;
    stop_st = stop_r;
    if (att_r) begin
      if (env_add > {1'b0, vegm_pkg::ENV_ONE}) begin
        env_st = vegm_pkg::ENV_ONE;
        att_st = 1'b0;
      end else begin
        env_st = env_add[16:0];
      end
    end else if (rel_r) begin
      if (cfg.release_step > env_r) begin
        env_st  = '0;
        stop_st = 1'b1;
      end else begin
        env_st = env_r - cfg.release_step;
      end
    end
    if (rdl_r == 16'd1) begin
      att_st = 1'b0;
      rel_st = 1'b1;
    end
  end

  always_comb begin
    st_nxt     = st_r;
    act_nxt    = act_r;
    src_l_nxt  = src_l_r;
    src_r_nxt  = src_r_r;
    pres_nxt   = pres_r;
    mix_l_nxt  = mix_l_r;
    mix_r_nxt  = mix_r_r;
    note_nxt   = note_r;
    dly_nxt    = dly_r;
    blk_nxt    = blk_r;
    g_nxt      = g_r;
    g2_nxt     = g2_r;
    acc_nxt    = acc_r;
    res_l_nxt  = res_l_r;
    res_r_nxt  = res_r_r;
    env_nxt    = env_r;
    att_nxt    = att_r;
    rel_nxt    = rel_r;
    play_nxt   = play_r;
    stop_nxt   = stop_r;
    vol_nxt    = vol_r;
    held_nxt   = held_r;
    sdl_nxt    = sdl_r;
    rdl_nxt    = rdl_r;
    o_l_nxt    = o_l_r;
    o_r_nxt    = o_r_r;
    o_play_nxt = o_play_r;
    o_env_nxt  = o_env_r;
    stop_dec   = stop_r;
    ov_nxt     = ov_r && !out_ch.ready;

    unique case (st_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          act_nxt   = in_ch.action;
          src_l_nxt = in_ch.source_left;
          src_r_nxt = in_ch.source_right;
          pres_nxt  = in_ch.source_present;
          mix_l_nxt = in_ch.mix_in_left;
          mix_r_nxt = in_ch.mix_in_right;
          note_nxt  = in_ch.note_volume;
          dly_nxt   = in_ch.delay_frames;
          blk_nxt   = in_ch.block_end;
          st_nxt    = ST_DEC;
        end
      end
      ST_DEC: begin
        res_l_nxt = mix_l_r;
        res_r_nxt = mix_r_r;
        st_nxt    = ST_OUT;
        unique case (act_r) inside
          vegm_pkg::ACT_ON: begin
            held_nxt = note_r;
            sdl_nxt  = dly_r;
            rdl_nxt  = '0;
            att_nxt  = 1'b1;
            rel_nxt  = 1'b0;
            env_nxt  = '0;
            play_nxt = 1'b1;
            stop_nxt = 1'b0;
          end
          vegm_pkg::ACT_OFF, vegm_pkg::ACT_KILL: begin
            if (act_r == vegm_pkg::ACT_KILL) begin
              env_nxt = '0;
            end
            if ((act_r == vegm_pkg::ACT_OFF) && (dly_r != 16'd0)) begin
              rdl_nxt = dly_r;
            end else begin
              att_nxt = 1'b0;
              rel_nxt = 1'b1;
            end
          end
          default: begin
            if (sdl_r != 16'd0) begin
              sdl_nxt = sdl_r - 16'd1;
            end else if (play_r && !pres_r) begin
              stop_dec = 1'b1;
            end else if (play_r) begin
              st_nxt = ST_G;
            end
            if (!(sdl_r == 16'd0 && play_r && pres_r)) begin
              if (blk_r && stop_dec) begin
                play_nxt = 1'b0;
                stop_nxt = 1'b0;
              end else begin
                stop_nxt = stop_dec;
              end
            end
          end
        endcase
      end
      ST_G: begin
        g_nxt  = mul_p[31:16];
        st_nxt = ST_G2;
      end
      ST_G2: begin
        g2_nxt = mul_p[31:0];
        st_nxt = ST_LL;
      end
      ST_LL: begin
        acc_nxt = p_ext + RND;
        st_nxt  = ST_LH;
      end
      ST_LH: begin
        acc_nxt = acc_r + (p_ext <<< 16);
        st_nxt  = ST_RL;
      end
      ST_RL: begin
        res_l_nxt = sat_v;
        acc_nxt   = p_ext + RND;
        st_nxt    = ST_RH;
      end
      ST_RH: begin
        acc_nxt = acc_r + (p_ext <<< 16);
        st_nxt  = ST_SL;
      end
      ST_SL: begin
        res_r_nxt = sat_v;
        vol_nxt   = vol_st;
        env_nxt   = env_st;
        att_nxt   = att_st;
        rel_nxt   = rel_st;
        if (rdl_r != 16'd0) begin
          rdl_nxt = rdl_r - 16'd1;
        end
        if (blk_r && stop_st) begin
          play_nxt = 1'b0;
          stop_nxt = 1'b0;
        end else begin
          stop_nxt = stop_st;
        end
        st_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt     = 1'b1;
          o_l_nxt    = res_l_r;
          o_r_nxt    = res_r_r;
          o_play_nxt = play_r;
          o_env_nxt  = env_r;
          st_nxt     = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      ov_r   <= 1'b0;
      env_r  <= '0;
      att_r  <= 1'b0;
      rel_r  <= 1'b0;
      play_r <= 1'b0;
      stop_r <= 1'b0;
      vol_r  <= vegm_pkg::VOL_UNITY;
      held_r <= '0;
      sdl_r  <= '0;
      rdl_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      ov_r   <= ov_nxt;
      env_r  <= env_nxt;
      att_r  <= att_nxt;
      rel_r  <= rel_nxt;
      play_r <= play_nxt;
      stop_r <= stop_nxt;
      vol_r  <= vol_nxt;
      held_r <= held_nxt;
      sdl_r  <= sdl_nxt;
      rdl_r  <= rdl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r    <= act_nxt;
    src_l_r  <= src_l_nxt;
    src_r_r  <= src_r_nxt;
    pres_r   <= pres_nxt;
    mix_l_r  <= mix_l_nxt;
    mix_r_r  <= mix_r_nxt;
    note_r   <= note_nxt;
    dly_r    <= dly_nxt;
    blk_r    <= blk_nxt;
    g_r      <= g_nxt;
    g2_r     <= g2_nxt;
    acc_r    <= acc_nxt;
    res_l_r  <= res_l_nxt;
    res_r_r  <= res_r_nxt;
    o_l_r    <= o_l_nxt;
    o_r_r    <= o_r_nxt;
    o_play_r <= o_play_nxt;
    o_env_r  <= o_env_nxt;
  end

endmodule

>>> hw/rtl/voice_envelope_gain_mixer_unit.sv
`timescale 1ns / 1ps
// Top level of the voice envelope gain mixer: register bank plus sequenced gain core.
// Depends on vegm_pkg, vegm_if, vegm_cfg, vegm_core and vegm_mul.
//
//   channel  dir  handshake      beat contents
//   in_ch    in   valid/ready    action, source, mix inputs, note volume, delay, block end
//   out_ch   out  valid/ready    out_left, out_right, playing, envelope_level
//   cfg_ch   in   valid/ready    register index, write data
//
// A mixed frame passes through the states DEC, G, G2, LL, LH, RL, RH, SL and OUT, with
// seven passes through the one shared multiplier (envelope by volume, by note volume,
// two halves per side, slew factor). Control events and unmixed frames pass through DEC
// and OUT only. in_ch.ready is high only when idle.
// A stalled out_ch holds the finished beat; the next beat is accepted and waits finished.
// rst_n is synchronous; cfg_ch is always ready.
module voice_envelope_gain_mixer_unit #(
  parameter int SAMPLE_BITS = vegm_pkg::SAMPLE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  vegm_in_if.sink    in_ch,
  vegm_out_if.source out_ch,
  vegm_cfg_if.sink   cfg_ch
);

  vegm_pkg::vegm_cfg_t cfg;

  vegm_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  vegm_core #(.SAMPLE_BITS(SAMPLE_BITS)) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
